FILE: design/paids_pkg.sv
// Shared types, codes and defaults for the positional array block.
`default_nettype none
package paids_pkg;

    localparam int DEPTH_DEFAULT = 16;

    // Request kinds as they arrive on the kind field.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SEARCH
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     capture;
    } cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/paids_cell.sv
// One storage cell of the array: shifts with its neighbors and compares against the key.
`default_nettype none
module paids_cell #(
    parameter int DEPTH = paids_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                   clk,
    input  wire paids_pkg::cell_cmd_t cmd,
    input  wire [IDX_W-1:0]       idx,
    input  wire [CNT_W-1:0]       count,
    input  wire signed [31:0]     value,
    input  wire signed [31:0]     left_data,
    input  wire signed [31:0]     right_data,
    output logic signed [31:0]    data,
    output logic                  match
);
    import paids_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic signed [31:0] data_reg;
    logic               match_reg;
    logic               match_next;

    // Only entries below the stored count take part in a search.
    assign match_next = (cmd.op == CELL_SEARCH) && (MY_CNT < count) && (data_reg == value);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            match_reg <= match_next;
            unique case (cmd.op)
                CELL_INSERT:
                begin
                    if (MY_IDX > idx)
                    begin
                        data_reg <= left_data;
                    end
                    else if (MY_IDX == idx)
                    begin
                        data_reg <= value;
                    end
                end
                CELL_DELETE:
                begin
                    if (MY_IDX >= idx)
                    begin
                        data_reg <= right_data;
                    end
                end
                CELL_HOLD, CELL_SEARCH:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule
`default_nettype wire

FILE: design/paids_first_match.sv
// Priority encoder that finds the lowest cell reporting a match.
`default_nettype none
module paids_first_match #(
    parameter int DEPTH = paids_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire [DEPTH-1:0]  hits,
    output logic             any,
    output logic [IDX_W-1:0] first
);
    import paids_pkg::*;

    always_comb
    begin
        first = '0;
        // Walk from the top so the lowest matching cell wins.
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                first = IDX_W'(i);
            end
        end
    end

    assign any = |hits;

endmodule
`default_nettype wire

FILE: design/positional_array_insert_delete_search.sv
// Top level of the positional array: request decode, cell row and result register.
//
// Requests enter on the in channel (kind, position, value) and each gives one result
// on the out channel (status, found, found_index, element_count). Both channels use
// valid/ready; a transfer happens when valid and ready are high at a clock edge.
// Insert and delete act on the row of cells at the edge that accepts the request: the
// cells from the position up shift from a neighbor or load the value. Search compares
// the key in every cell at the same edge and latches one match bit per cell.
// When the pending result moves to the output register, the lowest match is encoded
// into it; a result is offered once it reaches the output register.
// Throughput is one request per cycle unless the receiver stalls, set by the shift and
// compare in the cell row; a stage of pending results sits between the cells and the
// output register. When the receiver stalls, the output register holds its result, the
// pending stage fills, and in_ready drops until the output register is taken.
// Reset clears the count and all valid flags; cell contents stay undefined, and only
// entries below the count are ever compared, so unwritten cells never show.
`default_nettype none
module positional_array_insert_delete_search #(
    parameter int DEPTH = paids_pkg::DEPTH_DEFAULT
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire [1:0]         kind,
    input  wire [4:0]         position,
    input  wire signed [31:0] value,
    output logic              out_valid,
    input  wire               out_ready,
    output logic [1:0]        status,
    output logic              found,
    output logic [3:0]        found_index,
    output logic [4:0]        element_count
);
    import paids_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
    localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_valid_reg;
    logic [1:0]       pend_status_reg;
    logic [CNT_W-1:0] pend_count_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic             out_found_reg;
    logic [3:0]       out_index_reg;
    logic [4:0]       out_count_reg;

    logic             accept;
    logic             out_free;
    logic [1:0]       status_next;
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] cmd_idx;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;

    logic signed [31:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   cell_match;
    logic               any_match;
    logic [IDX_W-1:0]   first_idx;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !pend_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign cmd_idx = pos_m1[IDX_W-1:0];

    always_comb
    begin
        status_next = ST_RANGE;
        count_next  = count_reg;
        cmd.op      = CELL_HOLD;
        cmd.capture = accept;
        unique case (kind)
            KIND_INSERT:
            begin
                if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                begin
                    status_next = ST_RANGE;
                end
                else if (cnt_ext >= FULL_CNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg + CNT_W'(1);
                    cmd.op      = CELL_INSERT;
                end
            end
            KIND_DELETE:
            begin
                if (pos_ext == '0 || pos_ext > cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg - CNT_W'(1);
                    cmd.op      = CELL_DELETE;
                end
            end
            KIND_SEARCH:
            begin
                status_next = ST_DONE;
                cmd.op      = CELL_SEARCH;
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            paids_cell #(
                .DEPTH(DEPTH),
                .INDEX(gi),
                .IDX_W(IDX_W),
                .CNT_W(CNT_W)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .idx       (cmd_idx),
                .count     (count_reg),
                .value     (value),
                .left_data (left_d),
                .right_data(right_d),
                .data      (cell_data[gi]),
                .match     (cell_match[gi])
            );
        end
    endgenerate

    paids_first_match #(
        .DEPTH(DEPTH),
        .IDX_W(IDX_W)
    ) u_first_match (
        .hits (cell_match),
        .any  (any_match),
        .first(first_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_next;
            pend_count_reg  <= count_next;
        end
        if (out_free && pend_valid_reg)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= any_match;
            out_index_reg  <= any_match ? 4'(first_idx) : 4'd0;
            out_count_reg  <= 5'(pend_count_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found         = out_found_reg;
    assign found_index   = out_index_reg;
    assign element_count = out_count_reg;

endmodule
`default_nettype wire

FILE: design/paids_checker.sv
// Port-level checks on the positional array results, bound to the top level.
`default_nettype none
module paids_checker #(
    parameter int DEPTH = paids_pkg::DEPTH_DEFAULT
) (
    input wire               clk,
    input wire               rst_n,
    input wire               out_valid,
    input wire               out_ready,
    input wire [1:0]         status,
    input wire               found,
    input wire [3:0]         found_index,
    input wire [4:0]         element_count
);
    import paids_pkg::*;

    // A hit only comes from a search, which always completes.
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_DONE)
        else $error("found result without done status");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> found_index == 4'd0)
        else $error("nonzero index on a miss");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 31) || (int'(element_count) <= DEPTH))
        else $error("element count above depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> (DEPTH > 31) || (int'(element_count) == DEPTH))
        else $error("full status while not full");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(element_count))
        else $error("stalled result changed");

endmodule

bind positional_array_insert_delete_search paids_checker #(.DEPTH(DEPTH)) u_paids_checker (.*);
`default_nettype wire
